FILE: rtl/v3au_pkg.sv
// Types, constants and saturation helpers of the three-component vector unit.
package v3au_pkg;

  localparam int unsigned FracBits  = 16;
  localparam int unsigned DataW     = 32;
  localparam int unsigned TolW      = 17;
  localparam int unsigned SatW      = 68;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned QW        = 33;
  localparam int unsigned DivSteps  = QW;
  localparam int unsigned NumW      = 96;
  localparam int unsigned DenW      = 64;
  localparam int unsigned DivW      = DenW + QW;

  localparam logic [TolW-1:0]  TolReset = 17'd7;
  localparam logic [63:0]      OneRaw   = 64'(1) << FracBits;
  localparam logic [DataW-1:0] SatPos   = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] SatNeg   = 32'h8000_0000;
  localparam logic signed [SatW-1:0] SatMaxW = 68'sh0_7FFF_FFFF;
  localparam logic signed [SatW-1:0] SatMinW = -68'sh0_8000_0000;

  typedef enum logic [3:0] {
    CmdAdd   = 4'd0,
    CmdSub   = 4'd1,
    CmdNeg   = 4'd2,
    CmdScale = 4'd3,
    CmdDot   = 4'd4,
    CmdCross = 4'd5,
    CmdLenSq = 4'd6,
    CmdLen   = 4'd7,
    CmdNorm  = 4'd8,
    CmdProj  = 4'd9,
    CmdEqual = 4'd10,
    CmdZero  = 4'd11,
    CmdUnit  = 4'd12,
    CmdPar   = 4'd13,
    CmdPerp  = 4'd14
  } cmd_e;

  typedef struct packed {
    logic [2:0][DataW-1:0] vec;
    logic [DataW-1:0]      sc;
    logic                  flag;
    logic                  sat;
  } res_t;

  typedef struct packed {
    res_t                  res;
    cmd_e                  cmd;
    logic [2:0][DataW-1:0] amag;
    logic [2:0]            aneg;
    logic [2:0]            bneg;
    logic                  dneg;
    logic [DenW-1:0]       bb;
    logic [2:0][NumW-1:0]  prod;
  } sq_side_t;

  typedef struct packed {
    res_t             res;
    cmd_e             cmd;
    logic [DataW-1:0] root;
    logic             div_ok;
    logic [2:0]       rneg;
  } dv_side_t;

  // Returns {saturated, value} for a signed value clipped to 32 bits.
  function automatic logic [DataW:0] sat32(input logic signed [SatW-1:0] v);
    logic [DataW:0] r;
    if (v > SatMaxW) begin
      r = {1'b1, SatPos};
    end else if (v < SatMinW) begin
      r = {1'b1, SatNeg};
    end else begin
      r = {1'b0, v[DataW-1:0]};
    end
    return r;
  endfunction

  // Returns {saturated, value} for a sign and magnitude quotient.
  function automatic logic [DataW:0] sat_sm(input logic neg, input logic big,
                                            input logic [QW-1:0] q);
    logic [DataW:0] r;
    logic [QW-1:0]  nq;
    nq = '0 - q;
    if (big) begin
      r = {1'b1, (neg ? SatNeg : SatPos)};
    end else if (neg) begin
      if (q > 33'h0_8000_0000) begin
        r = {1'b1, SatNeg};
      end else begin
        r = {1'b0, nq[DataW-1:0]};
      end
    end else if (q > 33'h0_7FFF_FFFF) begin
      r = {1'b1, SatPos};
    end else begin
      r = {1'b0, q[DataW-1:0]};
    end
    return r;
  endfunction

endpackage

FILE: rtl/vector3_arithmetic_unit_core.sv
// Pipelined three-component vector unit in signed Q16.16 with saturation.
// Throughput: one beat per cycle while the output is not stalled; the 32 square root stages
// and the 33 divider stages set the depth, and a skid register at the output takes one beat
// while stalled.
// Reset clears every valid bit and the skid valid flag and sets the tolerance to 7.
module vector3_arithmetic_unit_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [16:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [3:0]          command_i,
  input  logic signed [31:0]  a_x_i,
  input  logic signed [31:0]  a_y_i,
  input  logic signed [31:0]  a_z_i,
  input  logic signed [31:0]  b_x_i,
  input  logic signed [31:0]  b_y_i,
  input  logic signed [31:0]  b_z_i,
  input  logic signed [31:0]  scale_factor_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  r_x_o,
  output logic signed [31:0]  r_y_o,
  output logic signed [31:0]  r_z_o,
  output logic signed [31:0]  scalar_out_o,
  output logic                flag_o,
  output logic                saturated_o
);

  import v3au_pkg::*;

  localparam int unsigned StSqrt0  = 6;
  localparam int unsigned StDivSet = StSqrt0 + SqrtSteps;
  localparam int unsigned StDiv0   = StDivSet + 1;
  localparam int unsigned StOut    = StDiv0 + DivSteps;
  localparam int unsigned NStg     = StOut + 1;

  logic            en;
  logic [NStg-1:0] vld_q;
  logic [TolW-1:0] tol_q;
  logic            skid_vld_q, skid_vld_d;
  res_t            skid_q, skid_d, out_q, out_d, res_o;

  // Stage 0: input registers.
  cmd_e               cmd0_q;
  logic signed [31:0] a0_q [3];
  logic signed [31:0] b0_q [3];
  logic signed [31:0] s0_q;

  // Stage 1: products.
  cmd_e               cmd1_q, cmd1_d;
  logic signed [63:0] ab1_q [3], ab1_d [3];
  logic signed [63:0] aa1_q [3], aa1_d [3];
  logic signed [63:0] bb1_q [3], bb1_d [3];
  logic signed [63:0] as1_q [3], as1_d [3];
  logic signed [63:0] cr1_q [6], cr1_d [6];
  logic signed [33:0] ev1_q [3], ev1_d [3];
  logic               eq1_q, eq1_d;
  logic [2:0][31:0]   amag1_q, amag1_d, bmag1_q, bmag1_d;
  logic [2:0]         aneg1_q, aneg1_d, bneg1_q, bneg1_d;

  // Stage 2: sums.
  cmd_e               cmd2_q;
  logic [2:0][31:0]   vpre2_q, vpre2_d;
  logic               vsat2_q, vsat2_d;
  logic signed [65:0] dot2_q, dot2_d;
  logic [63:0]        aa2_q, aa2_d, bb2_q, bb2_d;
  logic signed [64:0] cr2_q [3], cr2_d [3];
  logic               eq2_q;
  logic [2:0][31:0]   amag2_q, bmag2_q;
  logic [2:0]         aneg2_q, bneg2_q;

  // Stage 3: scaling back.
  cmd_e               cmd3_q;
  logic [2:0][31:0]   vpre3_q;
  logic               vsat3_q;
  logic signed [64:0] c3_q [3], c3_d [3];
  logic               cok3_q, cok3_d;
  logic [2:0][30:0]   cmag3_q, cmag3_d;
  logic [63:0]        dmag3_q, dmag3_d;
  logic               dneg3_q, dneg3_d;
  logic signed [65:0] dotq3_q, dotq3_d;
  logic [63:0]        la3_q, la3_d, lb3_q, lb3_d, aa3_q, bb3_q;
  logic               eq3_q;
  logic [2:0][31:0]   amag3_q, bmag3_q;
  logic [2:0]         aneg3_q, bneg3_q;

  // Stage 4: early results and second products.
  cmd_e               cmd4_q;
  res_t               res4_q, res4_d;
  logic               pz4_q, pz4_d, cok4_q;
  logic [2:0][61:0]   csq4_q, csq4_d;
  logic [2:0][63:0]   plo4_q, plo4_d, phi4_q, phi4_d;
  logic [63:0]        aa4_q, bb4_q;
  logic [2:0][31:0]   amag4_q;
  logic [2:0]         aneg4_q, bneg4_q;
  logic               dneg4_q;

  // Stage 5: parallel test and projection numerators.
  sq_side_t           side5_q, side5_d;
  logic [63:0]        aa5_q;

  // Square root stages.
  logic [63:0]        sqrem_q  [SqrtSteps];
  logic [63:0]        sqroot_q [SqrtSteps];
  sq_side_t           sqside_q [SqrtSteps];

  // Divider set-up stage.
  logic [2:0][DivW-1:0] dsrem_q, dsrem_d;
  logic [DenW-1:0]      dsden_q, dsden_d;
  logic [2:0]           dsbig_q, dsbig_d;
  dv_side_t             dsside_q, dsside_d;

  // Divider stages.
  logic [2:0][DivW-1:0] dvrem_q [DivSteps];
  logic [2:0][QW-1:0]   dvq_q   [DivSteps];
  logic [2:0]           dvbig_q [DivSteps];
  logic [DenW-1:0]      dvden_q [DivSteps];
  dv_side_t             dvside_q[DivSteps];

  assign en         = !skid_vld_q;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolReset;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      skid_vld_q <= 1'b0;
    end else begin
      skid_vld_q <= skid_vld_d;
      if (en) begin
        vld_q <= {vld_q[NStg-2:0], in_valid_i};
      end
    end
  end

  // Stage 0.
  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd0_q  <= cmd_e'(command_i);
      a0_q[0] <= a_x_i;
      a0_q[1] <= a_y_i;
      a0_q[2] <= a_z_i;
      b0_q[0] <= b_x_i;
      b0_q[1] <= b_y_i;
      b0_q[2] <= b_z_i;
      s0_q    <= scale_factor_i;
    end
  end

  // Stage 1.
  always_comb begin
    logic signed [32:0] diff;
    logic [32:0]        adiff;
    logic [32:0]        ma, mb;
    cmd1_d = cmd0_q;
    eq1_d  = 1'b1;
    for (int i = 0; i < 3; i++) begin
      ab1_d[i] = a0_q[i] * b0_q[i];
      aa1_d[i] = a0_q[i] * a0_q[i];
      bb1_d[i] = b0_q[i] * b0_q[i];
      as1_d[i] = a0_q[i] * s0_q;
      case (cmd0_q)
        CmdAdd:  ev1_d[i] = 34'(a0_q[i]) + 34'(b0_q[i]);
        CmdSub:  ev1_d[i] = 34'(a0_q[i]) - 34'(b0_q[i]);
        CmdNeg:  ev1_d[i] = 34'sd0 - 34'(a0_q[i]);
        default: ev1_d[i] = '0;
      endcase
      diff  = 33'(a0_q[i]) - 33'(b0_q[i]);
      adiff = diff[32] ? $unsigned(33'sd0 - diff) : $unsigned(diff);
      if (adiff > 33'(tol_q)) begin
        eq1_d = 1'b0;
      end
      ma = a0_q[i][31] ? $unsigned(33'sd0 - 33'(a0_q[i])) : $unsigned(33'(a0_q[i]));
      mb = b0_q[i][31] ? $unsigned(33'sd0 - 33'(b0_q[i])) : $unsigned(33'(b0_q[i]));
      amag1_d[i] = ma[31:0];
      bmag1_d[i] = mb[31:0];
      aneg1_d[i] = a0_q[i][31];
      bneg1_d[i] = b0_q[i][31];
    end
    cr1_d[0] = a0_q[1] * b0_q[2];
    cr1_d[1] = a0_q[2] * b0_q[1];
    cr1_d[2] = a0_q[2] * b0_q[0];
    cr1_d[3] = a0_q[0] * b0_q[2];
    cr1_d[4] = a0_q[0] * b0_q[1];
    cr1_d[5] = a0_q[1] * b0_q[0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd1_q  <= cmd1_d;
      ab1_q   <= ab1_d;
      aa1_q   <= aa1_d;
      bb1_q   <= bb1_d;
      as1_q   <= as1_d;
      cr1_q   <= cr1_d;
      ev1_q   <= ev1_d;
      eq1_q   <= eq1_d;
      amag1_q <= amag1_d;
      bmag1_q <= bmag1_d;
      aneg1_q <= aneg1_d;
      bneg1_q <= bneg1_d;
    end
  end

  // Stage 2.
  always_comb begin
    logic [32:0] t;
    vsat2_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      case (cmd1_q)
        CmdAdd, CmdSub, CmdNeg: t = sat32(SatW'(ev1_q[i]));
        CmdScale:               t = sat32(SatW'(as1_q[i] >>> FracBits));
        default:                t = '0;
      endcase
      vpre2_d[i] = t[31:0];
      vsat2_d    = vsat2_d | t[32];
    end
    dot2_d   = 66'(ab1_q[0]) + 66'(ab1_q[1]) + 66'(ab1_q[2]);
    aa2_d    = $unsigned(aa1_q[0]) + $unsigned(aa1_q[1]) + $unsigned(aa1_q[2]);
    bb2_d    = $unsigned(bb1_q[0]) + $unsigned(bb1_q[1]) + $unsigned(bb1_q[2]);
    cr2_d[0] = 65'(cr1_q[0]) - 65'(cr1_q[1]);
    cr2_d[1] = 65'(cr1_q[2]) - 65'(cr1_q[3]);
    cr2_d[2] = 65'(cr1_q[4]) - 65'(cr1_q[5]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd2_q  <= cmd1_q;
      vpre2_q <= vpre2_d;
      vsat2_q <= vsat2_d;
      dot2_q  <= dot2_d;
      aa2_q   <= aa2_d;
      bb2_q   <= bb2_d;
      cr2_q   <= cr2_d;
      eq2_q   <= eq1_q;
      amag2_q <= amag1_q;
      bmag2_q <= bmag1_q;
      aneg2_q <= aneg1_q;
      bneg2_q <= bneg1_q;
    end
  end

  // Stage 3.
  always_comb begin
    logic [64:0] cabs;
    logic [65:0] dabs;
    cok3_d = 1'b1;
    for (int i = 0; i < 3; i++) begin
      c3_d[i]    = cr2_q[i] >>> FracBits;
      cabs       = c3_d[i][64] ? $unsigned(65'sd0 - c3_d[i]) : $unsigned(c3_d[i]);
      cmag3_d[i] = cabs[30:0];
      if (cabs[64:31] != '0) begin
        cok3_d = 1'b0;
      end
    end
    dneg3_d = dot2_q[65];
    dabs    = dot2_q[65] ? $unsigned(66'sd0 - dot2_q) : $unsigned(dot2_q);
    dmag3_d = dabs[63:0];
    dotq3_d = dot2_q >>> FracBits;
    la3_d   = aa2_q >> FracBits;
    lb3_d   = bb2_q >> FracBits;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd3_q  <= cmd2_q;
      vpre3_q <= vpre2_q;
      vsat3_q <= vsat2_q;
      c3_q    <= c3_d;
      cok3_q  <= cok3_d;
      cmag3_q <= cmag3_d;
      dmag3_q <= dmag3_d;
      dneg3_q <= dneg3_d;
      dotq3_q <= dotq3_d;
      la3_q   <= la3_d;
      lb3_q   <= lb3_d;
      aa3_q   <= aa2_q;
      bb3_q   <= bb2_q;
      eq3_q   <= eq2_q;
      amag3_q <= amag2_q;
      bmag3_q <= bmag2_q;
      aneg3_q <= aneg2_q;
      bneg3_q <= bneg2_q;
    end
  end

  // Stage 4.
  always_comb begin
    logic [32:0] t;
    logic [65:0] dqabs;
    logic [63:0] u;
    t      = '0;
    res4_d = '0;
    pz4_d  = (la3_q > 64'(tol_q)) && (lb3_q > 64'(tol_q));
    dqabs  = dotq3_q[65] ? $unsigned(66'sd0 - dotq3_q) : $unsigned(dotq3_q);
    u      = (la3_q > OneRaw) ? (la3_q - OneRaw) : (OneRaw - la3_q);
    for (int i = 0; i < 3; i++) begin
      csq4_d[i] = cmag3_q[i] * cmag3_q[i];
      plo4_d[i] = bmag3_q[i] * dmag3_q[31:0];
      phi4_d[i] = bmag3_q[i] * dmag3_q[63:32];
    end
    case (cmd3_q)
      CmdAdd, CmdSub, CmdNeg, CmdScale: begin
        res4_d.vec = vpre3_q;
        res4_d.sat = vsat3_q;
      end
      CmdCross: begin
        for (int i = 0; i < 3; i++) begin
          t             = sat32(SatW'(c3_q[i]));
          res4_d.vec[i] = t[31:0];
          res4_d.sat    = res4_d.sat | t[32];
        end
      end
      CmdDot: begin
        t          = sat32(SatW'(dotq3_q));
        res4_d.sc  = t[31:0];
        res4_d.sat = t[32];
      end
      CmdLenSq: begin
        t          = sat32(SatW'($signed({1'b0, la3_q})));
        res4_d.sc  = t[31:0];
        res4_d.sat = t[32];
      end
      CmdEqual: res4_d.flag = eq3_q;
      CmdZero:  res4_d.flag = la3_q <= 64'(tol_q);
      CmdUnit:  res4_d.flag = u <= 64'(tol_q);
      CmdPerp:  res4_d.flag = pz4_d && (dqabs <= 66'(tol_q));
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd4_q  <= cmd3_q;
      res4_q  <= res4_d;
      pz4_q   <= pz4_d;
      cok4_q  <= cok3_q;
      csq4_q  <= csq4_d;
      plo4_q  <= plo4_d;
      phi4_q  <= phi4_d;
      aa4_q   <= aa3_q;
      bb4_q   <= bb3_q;
      amag4_q <= amag3_q;
      aneg4_q <= aneg3_q;
      bneg4_q <= bneg3_q;
      dneg4_q <= dneg3_q;
    end
  end

  // Stage 5.
  always_comb begin
    logic [63:0] csum;
    csum         = 64'(csq4_q[0]) + 64'(csq4_q[1]) + 64'(csq4_q[2]);
    side5_d.res  = res4_q;
    side5_d.cmd  = cmd4_q;
    side5_d.amag = amag4_q;
    side5_d.aneg = aneg4_q;
    side5_d.bneg = bneg4_q;
    side5_d.dneg = dneg4_q;
    side5_d.bb   = bb4_q;
    for (int i = 0; i < 3; i++) begin
      side5_d.prod[i] = NumW'(plo4_q[i]) + (NumW'(phi4_q[i]) << 32);
    end
    if (cmd4_q == CmdPar) begin
      side5_d.res.flag = pz4_q && cok4_q && ((csum >> FracBits) <= 64'(tol_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side5_q <= side5_d;
      aa5_q   <= aa4_q;
    end
  end

  // Square root, two radicand bits per stage.
  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    localparam logic [63:0] SqBit = 64'(1) << (2 * SqrtSteps - 2 - 2 * k);
    logic [63:0] rem_in, root_in, sum, rem_d, root_d;
    sq_side_t    side_in;
    logic        take;
    if (k == 0) begin : g_first
      assign rem_in  = aa5_q;
      assign root_in = '0;
      assign side_in = side5_q;
    end else begin : g_next
      assign rem_in  = sqrem_q[k-1];
      assign root_in = sqroot_q[k-1];
      assign side_in = sqside_q[k-1];
    end
    assign sum    = root_in + SqBit;
    assign take   = rem_in >= sum;
    assign rem_d  = take ? (rem_in - sum) : rem_in;
    assign root_d = take ? ((root_in >> 1) + SqBit) : (root_in >> 1);
    always_ff @(posedge clk_i) begin
      if (en) begin
        sqrem_q[k]  <= rem_d;
        sqroot_q[k] <= root_d;
        sqside_q[k] <= side_in;
      end
    end
  end

  // Divider set-up.
  always_comb begin
    sq_side_t         sq;
    logic [DataW-1:0] root;
    logic [2:0][NumW-1:0] num;
    sq   = sqside_q[SqrtSteps-1];
    root = sqroot_q[SqrtSteps-1][DataW-1:0];
    dsside_d.res  = sq.res;
    dsside_d.cmd  = sq.cmd;
    dsside_d.root = root;
    num           = '0;
    case (sq.cmd)
      CmdNorm: begin
        dsden_d         = DenW'(root);
        dsside_d.div_ok = DenW'(root) > DenW'(tol_q);
        for (int i = 0; i < 3; i++) begin
          num[i] = NumW'(sq.amag[i]) << FracBits;
        end
        dsside_d.rneg = sq.aneg;
      end
      CmdProj: begin
        dsden_d         = sq.bb;
        dsside_d.div_ok = (sq.bb >> FracBits) > DenW'(tol_q);
        num             = sq.prod;
        dsside_d.rneg   = sq.bneg ^ {3{sq.dneg}};
      end
      default: begin
        dsden_d         = '0;
        dsside_d.div_ok = 1'b0;
        dsside_d.rneg   = '0;
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      dsrem_d[i] = DivW'(num[i]);
      dsbig_d[i] = DivW'(num[i]) >= (DivW'(dsden_d) << QW);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dsrem_q  <= dsrem_d;
      dsden_q  <= dsden_d;
      dsbig_q  <= dsbig_d;
      dsside_q <= dsside_d;
    end
  end

  // Restoring division, one quotient bit per stage in each lane.
  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    localparam int unsigned Shift = QW - 1 - j;
    logic [2:0][DivW-1:0] rem_in, rem_d;
    logic [2:0][QW-1:0]   q_in, q_d;
    logic [2:0]           big_in;
    logic [DenW-1:0]      den_in;
    dv_side_t             side_in;
    logic [DivW-1:0]      cmp;
    if (j == 0) begin : g_first
      assign rem_in  = dsrem_q;
      assign q_in    = '0;
      assign big_in  = dsbig_q;
      assign den_in  = dsden_q;
      assign side_in = dsside_q;
    end else begin : g_next
      assign rem_in  = dvrem_q[j-1];
      assign q_in    = dvq_q[j-1];
      assign big_in  = dvbig_q[j-1];
      assign den_in  = dvden_q[j-1];
      assign side_in = dvside_q[j-1];
    end
    assign cmp = DivW'(den_in) << Shift;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        if (rem_in[i] >= cmp) begin
          rem_d[i] = rem_in[i] - cmp;
          q_d[i]   = {q_in[i][QW-2:0], 1'b1};
        end else begin
          rem_d[i] = rem_in[i];
          q_d[i]   = {q_in[i][QW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dvrem_q[j]  <= rem_d;
        dvq_q[j]    <= q_d;
        dvbig_q[j]  <= big_in;
        dvden_q[j]  <= den_in;
        dvside_q[j] <= side_in;
      end
    end
  end

  // Output stage.
  always_comb begin
    dv_side_t    sd;
    logic [32:0] t;
    t     = '0;
    sd    = dvside_q[DivSteps-1];
    out_d = sd.res;
    case (sd.cmd)
      CmdLen: begin
        t         = sat_sm(1'b0, 1'b0, QW'(sd.root));
        out_d.sc  = t[31:0];
        out_d.sat = t[32];
      end
      CmdNorm, CmdProj: begin
        if (sd.div_ok) begin
          for (int i = 0; i < 3; i++) begin
            t            = sat_sm(sd.rneg[i], dvbig_q[DivSteps-1][i], dvq_q[DivSteps-1][i]);
            out_d.vec[i] = t[31:0];
            out_d.sat    = out_d.sat | t[32];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  // Skid register: holds the last stage's beat while the output stalls.
  always_comb begin
    if (skid_vld_q) begin
      skid_vld_d = !out_ready_i;
      skid_d     = skid_q;
    end else begin
      skid_vld_d = vld_q[NStg-1] && !out_ready_i;
      skid_d     = out_q;
    end
  end

  always_ff @(posedge clk_i) begin
    skid_q <= skid_d;
  end

  assign res_o        = skid_vld_q ? skid_q : out_q;
  assign out_valid_o  = skid_vld_q | vld_q[NStg-1];
  assign r_x_o        = res_o.vec[0];
  assign r_y_o        = res_o.vec[1];
  assign r_z_o        = res_o.vec[2];
  assign scalar_out_o = res_o.sc;
  assign flag_o       = res_o.flag;
  assign saturated_o  = res_o.sat;

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the three-component vector arithmetic unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import v3au_pkg::*;

  localparam logic [3:0] CmdNone = 4'd15;
  localparam int WatchLimit = 4000;
  localparam int DrainCycles = 80;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [3:0]         cmd;
    logic signed [31:0] a [3];
    logic signed [31:0] b [3];
    logic signed [31:0] s;
  } vec_op_t;

  typedef struct {
    logic [31:0] r [3];
    logic [31:0] sc;
    logic        flag;
    logic        sat;
  } vec_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [16:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [3:0] command_i = '0;
  logic signed [31:0] a_x_i = '0, a_y_i = '0, a_z_i = '0;
  logic signed [31:0] b_x_i = '0, b_y_i = '0, b_z_i = '0;
  logic signed [31:0] scale_factor_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] r_x_o, r_y_o, r_z_o, scalar_out_o;
  logic flag_o, saturated_o;

  vec_res_t pending_results [$];
  logic [16:0] tol_now = TolReset;
  int error_cnt = 0;
  int idle_cnt = 0;
  int stall_cnt = 0;
  bit idle_en = 1'b1;
  bit long_hold_req = 1'b0;

  vector3_arithmetic_unit_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .command_i(command_i),
    .a_x_i(a_x_i), .a_y_i(a_y_i), .a_z_i(a_z_i),
    .b_x_i(b_x_i), .b_y_i(b_y_i), .b_z_i(b_z_i),
    .scale_factor_i(scale_factor_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .r_x_o(r_x_o), .r_y_o(r_y_o), .r_z_o(r_z_o),
    .scalar_out_o(scalar_out_o), .flag_o(flag_o), .saturated_o(saturated_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [31:0] clip(input wide_t v, inout logic sat);
    if (v > wide_t'(32'sh7FFF_FFFF)) begin
      sat = 1'b1;
      return SatPos;
    end else if (v < -wide_t'(64'sh8000_0000)) begin
      sat = 1'b1;
      return SatNeg;
    end
    return v[31:0];
  endfunction

  function automatic wide_t magn(input wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] bt;
    r = '0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= r + bt) begin
        v = v - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  function automatic vec_res_t vec_predict(input vec_op_t op);
    vec_res_t res;
    wide_t a [3];
    wide_t b [3];
    wide_t c [3];
    wide_t s, t, d, lsa, lsb, acc;
    logic sat;
    logic ok;
    sat = 1'b0;
    res.r[0] = '0; res.r[1] = '0; res.r[2] = '0;
    res.sc = '0;
    res.flag = 1'b0;
    for (int i = 0; i < 3; i++) begin
      a[i] = op.a[i];
      b[i] = op.b[i];
    end
    s = op.s;
    c[0] = (a[1] * b[2] - a[2] * b[1]) >>> FracBits;
    c[1] = (a[2] * b[0] - a[0] * b[2]) >>> FracBits;
    c[2] = (a[0] * b[1] - a[1] * b[0]) >>> FracBits;
    d = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    lsa = (a[0] * a[0] + a[1] * a[1] + a[2] * a[2]) >>> FracBits;
    lsb = (b[0] * b[0] + b[1] * b[1] + b[2] * b[2]) >>> FracBits;
    case (op.cmd)
      CmdAdd:   for (int i = 0; i < 3; i++) res.r[i] = clip(a[i] + b[i], sat);
      CmdSub:   for (int i = 0; i < 3; i++) res.r[i] = clip(a[i] - b[i], sat);
      CmdNeg:   for (int i = 0; i < 3; i++) res.r[i] = clip(-a[i], sat);
      CmdScale: for (int i = 0; i < 3; i++) res.r[i] = clip((a[i] * s) >>> FracBits, sat);
      CmdDot:   res.sc = clip(d >>> FracBits, sat);
      CmdCross: for (int i = 0; i < 3; i++) res.r[i] = clip(c[i], sat);
      CmdLenSq: res.sc = clip(lsa, sat);
      CmdLen: begin
        t = isqrt(64'(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]));
        res.sc = clip(t, sat);
      end
      CmdNorm: begin
        t = isqrt(64'(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]));
        if (t > tol_now) begin
          for (int i = 0; i < 3; i++) res.r[i] = clip((a[i] * wide_t'(OneRaw)) / t, sat);
        end
      end
      CmdProj: begin
        t = b[0] * b[0] + b[1] * b[1] + b[2] * b[2];
        if ((t >>> FracBits) > tol_now) begin
          for (int i = 0; i < 3; i++) res.r[i] = clip((b[i] * d) / t, sat);
        end
      end
      CmdEqual: begin
        res.flag = 1'b1;
        for (int i = 0; i < 3; i++) if (magn(a[i] - b[i]) > tol_now) res.flag = 1'b0;
      end
      CmdZero: res.flag = (lsa <= tol_now);
      CmdUnit: res.flag = (magn(lsa - wide_t'(OneRaw)) <= tol_now);
      CmdPar: begin
        if (lsa > tol_now && lsb > tol_now) begin
          ok = 1'b1;
          acc = '0;
          for (int i = 0; i < 3; i++) begin
            if (magn(c[i]) >= wide_t'(64'h8000_0000)) ok = 1'b0;
            else acc = acc + c[i] * c[i];
          end
          res.flag = ok && ((acc >>> FracBits) <= tol_now);
        end
      end
      CmdPerp: begin
        if (lsa > tol_now && lsb > tol_now) res.flag = (magn(d >>> FracBits) <= tol_now);
      end
      default: ;
    endcase
    res.sat = sat;
    return res;
  endfunction

  function automatic vec_op_t mk_op(input logic [3:0] cmd, input int ax, input int ay,
                                    input int az, input int bx, input int by, input int bz,
                                    input int s);
    vec_op_t op;
    op.cmd = cmd;
    op.a[0] = ax; op.a[1] = ay; op.a[2] = az;
    op.b[0] = bx; op.b[1] = by; op.b[2] = bz;
    op.s = s;
    return op;
  endfunction

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 524288)) - 262144;
      2: begin
        case ($urandom_range(0, 6))
          0: return 0;
          1: return 1;
          2: return -1;
          3: return 65536;
          4: return -65536;
          5: return 32'sh7FFF_FFFF;
          default: return 32'sh8000_0000;
        endcase
      end
      default: return $signed($urandom) >>> 12;
    endcase
  endfunction

  function automatic vec_op_t rand_op();
    vec_op_t op;
    int k;
    int bias;
    op.cmd = 4'($urandom_range(0, 15));
    for (int i = 0; i < 3; i++) begin
      op.a[i] = rand_val();
      op.b[i] = rand_val();
    end
    op.s = rand_val();
    bias = $urandom_range(0, 1);
    case ($urandom_range(0, 9))
      4: begin
        for (int i = 0; i < 3; i++) op.b[i] = op.a[i] + $signed($urandom_range(0, 20)) - 10;
        if (bias) op.cmd = CmdEqual;
      end
      5: begin
        k = $signed($urandom_range(0, 6)) - 3;
        for (int i = 0; i < 3; i++) begin
          op.a[i] = $signed($urandom_range(0, 524288)) - 262144;
          op.b[i] = op.a[i] * k;
        end
        if (bias) op.cmd = CmdPar;
      end
      6: begin
        op.a[2] = $signed($urandom_range(0, 524288)) - 262144;
        op.a[0] = $signed($urandom_range(0, 524288)) - 262144;
        op.a[1] = $signed($urandom_range(0, 524288)) - 262144;
        op.b[0] = -op.a[1];
        op.b[1] = op.a[0];
        op.a[2] = 0;
        if (bias) op.cmd = CmdPerp;
      end
      7: begin
        k = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++) op.a[i] = $signed($urandom_range(0, 40)) - 20;
        op.a[k] = op.a[k] + ($urandom_range(0, 1) ? 65536 : -65536);
        if (bias) op.cmd = CmdUnit;
      end
      8: begin
        for (int i = 0; i < 3; i++) begin
          op.a[i] = $signed($urandom_range(0, 64)) - 32;
          op.b[i] = $signed($urandom_range(0, 64)) - 32;
        end
      end
      default: ;
    endcase
    return op;
  endfunction

  task automatic send_op(input vec_op_t op);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= op.cmd;
    a_x_i <= op.a[0]; a_y_i <= op.a[1]; a_z_i <= op.a[2];
    b_x_i <= op.b[0]; b_y_i <= op.b[1]; b_z_i <= op.b[2];
    scale_factor_i <= op.s;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    pending_results.push_back(vec_predict(op));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_tol(input logic [16:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    tol_now = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_directed();
    int mx;
    int mn;
    mx = 32'sh7FFF_FFFF;
    mn = 32'sh8000_0000;
    send_op(mk_op(CmdAdd, mx, mn, 1, 1, -1, -1, 0));
    send_op(mk_op(CmdSub, mn, mx, 0, 1, -1, 0, 0));
    send_op(mk_op(CmdNeg, mn, mx, 0, 0, 0, 0, 0));
    send_op(mk_op(CmdScale, mx, mn, -65536, 0, 0, 0, mn));
    send_op(mk_op(CmdScale, 65536, -3, 98304, 0, 0, 0, -32768));
    send_op(mk_op(CmdDot, mx, mx, mx, mx, mx, mx, 0));
    send_op(mk_op(CmdDot, -1, 0, 0, 1, 0, 0, 0));
    send_op(mk_op(CmdCross, 65536, 0, 0, 0, 65536, 0, 0));
    send_op(mk_op(CmdCross, mn, mx, mn, mx, mn, mx, 0));
    send_op(mk_op(CmdLenSq, mn, mn, mn, 0, 0, 0, 0));
    send_op(mk_op(CmdLen, mn, mn, mn, 0, 0, 0, 0));
    send_op(mk_op(CmdLen, 3 << 16, 4 << 16, 0, 0, 0, 0, 0));
    send_op(mk_op(CmdNorm, 0, 0, 0, 0, 0, 0, 0));
    send_op(mk_op(CmdNorm, 3, 4, 0, 0, 0, 0, 0));
    send_op(mk_op(CmdNorm, mn, 1, -5, 0, 0, 0, 0));
    send_op(mk_op(CmdProj, 65536, 65536, 0, 0, 0, 0, 0));
    send_op(mk_op(CmdProj, mx, mx, mx, 1024, -1024, 0, 0));
    send_op(mk_op(CmdProj, 5 << 16, 7 << 16, -2, 2 << 16, 0, 0, 0));
    send_op(mk_op(CmdEqual, 100, -100, 0, 107, -93, 7, 0));
    send_op(mk_op(CmdEqual, mx, 0, 0, mn, 0, 0, 0));
    send_op(mk_op(CmdZero, 200, 0, 0, 0, 0, 0, 0));
    send_op(mk_op(CmdUnit, 65536, 0, 0, 0, 0, 0, 0));
    send_op(mk_op(CmdPar, 65536, 131072, 0, -131072, -262144, 0, 0));
    send_op(mk_op(CmdPerp, 65536, 0, 0, 0, 0, 65536, 0));
    send_op(mk_op(CmdPar, 0, 0, 0, 65536, 0, 0, 0));
    send_op(mk_op(CmdNone, mx, mx, mx, mx, mx, mx, mx));
  endtask

  task automatic test_tolerance();
    logic [16:0] tols [4];
    tols[0] = 17'd0; tols[1] = 17'd65536; tols[2] = 17'd1000; tols[3] = 17'd200;
    foreach (tols[j]) begin
      write_tol(tols[j]);
      for (int c = 0; c <= 15; c++) begin
        vec_op_t op;
        op = rand_op();
        op.cmd = 4'(c);
        send_op(op);
      end
      send_op(mk_op(CmdNorm, 100, 100, 0, 0, 0, 0, 0));
      send_op(mk_op(CmdProj, 65536, 0, 0, 300, 300, 0, 0));
    end
  endtask

  task automatic test_backpressure();
    drain();
    idle_en = 1'b0;
    long_hold_req = 1'b1;
    repeat (150) send_op(rand_op());
    drain();
    idle_en = 1'b1;
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 4; ph++) begin
      write_tol(ph == 3 ? 17'd7 : 17'($urandom_range(0, 65536)));
      for (int n = 0; n < 200; n++) begin
        if (ph == 3 && n == 50) idle_en = 1'b0;
        send_op(rand_op());
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_tolerance();
    test_backpressure();
    test_random();
    drain();
    if (error_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (stall_cnt > 0) begin
      out_ready_i <= 1'b0;
      stall_cnt <= stall_cnt - 1;
    end else if (long_hold_req) begin
      out_ready_i <= 1'b0;
      stall_cnt <= 200;
      long_hold_req = 1'b0;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      out_ready_i <= 1'b0;
      stall_cnt <= $urandom_range(0, 5);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(negedge clk_i) begin
    vec_res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("beat received with no result expected");
        error_cnt++;
      end else begin
        e = pending_results.pop_front();
        if (r_x_o !== e.r[0]) begin
          $error("r_x expected %h got %h", e.r[0], r_x_o);
          error_cnt++;
        end
        if (r_y_o !== e.r[1]) begin
          $error("r_y expected %h got %h", e.r[1], r_y_o);
          error_cnt++;
        end
        if (r_z_o !== e.r[2]) begin
          $error("r_z expected %h got %h", e.r[2], r_z_o);
          error_cnt++;
        end
        if (scalar_out_o !== e.sc) begin
          $error("scalar_out expected %h got %h", e.sc, scalar_out_o);
          error_cnt++;
        end
        if (flag_o !== e.flag) begin
          $error("flag expected %b got %b", e.flag, flag_o);
          error_cnt++;
        end
        if (saturated_o !== e.sat) begin
          $error("saturated expected %b got %b", e.sat, saturated_o);
          error_cnt++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WatchLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

endmodule
